// ===== rtl/srtm_pkg.sv =====
// Shared types, codes and helpers for the sorted record table block.
package srtm_pkg;

   localparam int TABLE_DEPTH_DEF = 32;
   localparam int NAME_BYTES      = 8;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_MERGE  = 2'd2,
      OP_THRESH = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_RECORD   = 3'd0,
      ST_MISS     = 3'd1,
      ST_INSERTED = 3'd2,
      ST_FULL     = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   typedef struct packed {
      logic [63:0] name;
      logic [30:0] id;
      logic [15:0] key;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef struct packed {
      logic load;
      logic ins_step;
      logic srch_step;
      logic mrg_step;
      logic fin_full;
      logic emit_fin;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   full;
      logic   ins_done;
      logic   srch_done;
      logic   mrg_end;
      logic   mrg_hold;
      logic   out_free;
   } sts_type;

   // Keep bytes up to the first zero byte or NAME_BYTES, clear the rest.
   function automatic logic [63:0] norm_name(input logic [63:0] v);
      logic [63:0] r;
      logic        stop;
      r    = '0;
      stop = 1'b0;
      for (int b = 0; b < 8; b++) begin
         if (b >= NAME_BYTES || v[8*b +: 8] == 8'h00) begin
            stop = 1'b1;
         end
         if (!stop) begin
            r[8*b +: 8] = v[8*b +: 8];
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/srtm_ram.sv =====
// Generic single write port RAM with one registered read port.
module srtm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/srtm_ctrl.sv =====
// Sequencer for insert, search and merge walks of the record tables.
module srtm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  srtm_pkg::sts_type sts,
   output srtm_pkg::cmd_type cmd
);

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_START    = 8'b0000_0010,
      S_INS_RD   = 8'b0000_0100,
      S_INS_CHK  = 8'b0000_1000,
      S_SRCH_RD  = 8'b0001_0000,
      S_SRCH_CHK = 8'b0010_0000,
      S_MRG_RD   = 8'b0100_0000,
      S_MRG_CHK  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      emit_ff, emit_in;

   always_comb begin
      state_in = state_ff;
      emit_in  = emit_ff;
      cmd      = '0;
      if (emit_ff) begin
         // final result waits for a free output slot
         cmd.emit_fin = 1'b1;
         if (sts.out_free) begin
            emit_in  = 1'b0;
            state_in = S_IDLE;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd.load = 1'b1;
                  state_in = S_START;
               end
            end
            S_START: begin
               case (sts.op)
                  srtm_pkg::OP_INSERT: begin
                     if (sts.full) begin
                        cmd.fin_full = 1'b1;
                        emit_in      = 1'b1;
                     end else begin
                        state_in = S_INS_RD;
                     end
                  end
                  srtm_pkg::OP_SEARCH: state_in = S_SRCH_RD;
                  default:             state_in = S_MRG_RD;
               endcase
            end
            S_INS_RD:  state_in = S_INS_CHK;
            S_INS_CHK: begin
               cmd.ins_step = 1'b1;
               if (sts.ins_done) begin
                  emit_in = 1'b1;
               end else begin
                  state_in = S_INS_RD;
               end
            end
            S_SRCH_RD:  state_in = S_SRCH_CHK;
            S_SRCH_CHK: begin
               cmd.srch_step = 1'b1;
               if (sts.srch_done) begin
                  emit_in = 1'b1;
               end else begin
                  state_in = S_SRCH_RD;
               end
            end
            S_MRG_RD:  state_in = S_MRG_CHK;
            S_MRG_CHK: begin
               cmd.mrg_step = 1'b1;
               if (sts.mrg_end) begin
                  emit_in = 1'b1;
               end else if (!sts.mrg_hold) begin
                  state_in = S_MRG_RD;
               end
            end
            default: state_in = S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         emit_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         emit_ff  <= emit_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE) || emit_ff;

endmodule

// ===== rtl/srtm_datapath.sv =====
// Record stores, walk pointers, pending record and output register.
module srtm_datapath #(
   parameter int TABLE_DEPTH = srtm_pkg::TABLE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  srtm_pkg::cmd_type        cmd,
   output srtm_pkg::sts_type        sts,
   input  logic [1:0]               req_operation,
   input  logic                     req_table_sel,
   input  logic [30:0]              req_record_id,
   input  logic signed [15:0]       req_key_value,
   input  logic [63:0]              req_name_text,
   input  logic signed [15:0]       req_threshold,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_status,
   output logic [30:0]              rsp_out_id,
   output logic signed [15:0]       rsp_out_key,
   output logic [63:0]              rsp_out_name,
   output logic                     rsp_last
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   srtm_pkg::op_type     op_ff, op_in;
   logic                 t_ff, t_in;
   srtm_pkg::rec_type    new_ff, new_in;
   logic [15:0]          thr_ff, thr_in;
   logic [CW-1:0]        fill_ff [2];
   logic [CW-1:0]        fill_in [2];
   logic [CW-1:0]        idx_ff, idx_in, a_ff, a_in, b_ff, b_in;
   srtm_pkg::rec_type    pend_ff, pend_in, fin_ff, fin_in;
   logic                 pend_valid_ff, pend_valid_in;
   srtm_pkg::status_type fin_status_ff, fin_status_in;
   srtm_pkg::rec_type    out_ff, out_in;
   srtm_pkg::status_type out_status_ff, out_status_in;
   logic                 out_last_ff, out_last_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   srtm_pkg::rec_type rd0, rd1, rd_t, chosen;
   logic [CW-1:0] ptr;
   logic [AW-1:0] ptr_addr, addr0, addr1;
   logic          is_mrg, a_ok, b_ok, sel0, qual, out_free, wr_en0, wr_en1;
   srtm_pkg::rec_type wr_rec;

   assign is_mrg   = (op_ff == srtm_pkg::OP_MERGE) || (op_ff == srtm_pkg::OP_THRESH);
   assign ptr      = (op_ff == srtm_pkg::OP_INSERT) ? idx_ff - CW'(1) : idx_ff;
   assign ptr_addr = ptr[AW-1:0];
   assign addr0    = is_mrg ? a_ff[AW-1:0] : ptr_addr;
   assign addr1    = is_mrg ? b_ff[AW-1:0] : ptr_addr;
   assign rd_t     = t_ff ? rd1 : rd0;

   assign a_ok   = a_ff < fill_ff[0];
   assign b_ok   = b_ff < fill_ff[1];
   assign sel0   = !b_ok || (a_ok && ($signed(rd0.key) >= $signed(rd1.key)));
   assign chosen = sel0 ? rd0 : rd1;
   assign qual   = (op_ff != srtm_pkg::OP_THRESH) ||
                   ($signed(chosen.key) >= $signed(thr_ff));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign sts.op        = op_ff;
   assign sts.full      = fill_ff[t_ff] == CW'(TABLE_DEPTH);
   assign sts.ins_done  = (idx_ff == '0) || ($signed(rd_t.key) > $signed(new_ff.key));
   assign sts.srch_done = (idx_ff >= fill_ff[t_ff]) || (rd_t.name == new_ff.name);
   assign sts.mrg_end   = !a_ok && !b_ok;
   assign sts.mrg_hold  = qual && pend_valid_ff && !out_free;
   assign sts.out_free  = out_free;

   assign wr_rec = sts.ins_done ? new_ff : rd_t;
   assign wr_en0 = cmd.ins_step && !t_ff;
   assign wr_en1 = cmd.ins_step && t_ff;

   srtm_ram #(.WIDTH(srtm_pkg::REC_W), .DEPTH(TABLE_DEPTH)) u_ram0 (
      .clock   (clock),
      .wr_en   (wr_en0),
      .wr_addr (idx_ff[AW-1:0]),
      .wr_data (wr_rec),
      .rd_addr (addr0),
      .rd_data (rd0)
   );

   srtm_ram #(.WIDTH(srtm_pkg::REC_W), .DEPTH(TABLE_DEPTH)) u_ram1 (
      .clock   (clock),
      .wr_en   (wr_en1),
      .wr_addr (idx_ff[AW-1:0]),
      .wr_data (wr_rec),
      .rd_addr (addr1),
      .rd_data (rd1)
   );

   always_comb begin
      op_in         = op_ff;
      t_in          = t_ff;
      new_in        = new_ff;
      thr_in        = thr_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      fin_in        = fin_ff;
      fin_status_in = fin_status_ff;
      out_in        = out_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (cmd.load) begin
         op_in         = srtm_pkg::op_type'(req_operation);
         t_in          = req_table_sel;
         new_in.id     = req_record_id;
         new_in.key    = req_key_value;
         new_in.name   = srtm_pkg::norm_name(req_name_text);
         thr_in        = req_threshold;
         idx_in        = (req_operation == srtm_pkg::OP_INSERT) ?
                         fill_ff[req_table_sel] : '0;
         a_in          = '0;
         b_in          = '0;
         pend_valid_in = 1'b0;
      end

      if (cmd.fin_full) begin
         fin_in        = new_ff;
         fin_status_in = srtm_pkg::ST_FULL;
      end

      if (cmd.ins_step) begin
         if (sts.ins_done) begin
            fill_in[t_ff] = fill_ff[t_ff] + CW'(1);
            fin_in        = new_ff;
            fin_status_in = srtm_pkg::ST_INSERTED;
         end else begin
            idx_in = idx_ff - CW'(1);
         end
      end

      if (cmd.srch_step) begin
         if (idx_ff >= fill_ff[t_ff]) begin
            fin_in        = '0;
            fin_status_in = srtm_pkg::ST_MISS;
         end else if (rd_t.name == new_ff.name) begin
            fin_in        = rd_t;
            fin_status_in = srtm_pkg::ST_RECORD;
         end else begin
            idx_in = idx_ff + CW'(1);
         end
      end

      if (cmd.mrg_step) begin
         if (sts.mrg_end) begin
            fin_in        = pend_valid_ff ? pend_ff : '0;
            fin_status_in = pend_valid_ff ? srtm_pkg::ST_RECORD : srtm_pkg::ST_EMPTY;
         end else if (!sts.mrg_hold) begin
            if (qual) begin
               // hand the previous record on, hold the new one back
               if (pend_valid_ff) begin
                  out_in        = pend_ff;
                  out_status_in = srtm_pkg::ST_RECORD;
                  out_last_in   = 1'b0;
                  rsp_valid_in  = 1'b1;
               end
               pend_in       = chosen;
               pend_valid_in = 1'b1;
            end
            if (sel0) begin
               a_in = a_ff + CW'(1);
            end else begin
               b_in = b_ff + CW'(1);
            end
         end
      end

      if (cmd.emit_fin && out_free) begin
         out_in        = fin_ff;
         out_status_in = fin_status_ff;
         out_last_in   = 1'b1;
         rsp_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff[0]    <= '0;
         fill_ff[1]    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      t_ff          <= t_in;
      new_ff        <= new_in;
      thr_ff        <= thr_in;
      idx_ff        <= idx_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      pend_ff       <= pend_in;
      fin_ff        <= fin_in;
      fin_status_ff <= fin_status_in;
      out_ff        <= out_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = out_status_ff;
   assign rsp_out_id   = out_ff.id;
   assign rsp_out_key  = out_ff.key;
   assign rsp_out_name = out_ff.name;
   assign rsp_last     = out_last_ff;

endmodule

// ===== rtl/sorted_record_table_with_merge_core.sv =====
// Top level of the sorted record table: sequencer plus record datapath.
//
// Two tables of (id, name, key) records, each kept in descending key order.
// Request channel (req_*): one beat carries an operation - insert, search by
// name, merged listing, or merged listing at or above a threshold. req_stall
// is high while a request is being worked on; one request is handled at a time.
// Response channel (rsp_*): each request yields one or more beats, and
// rsp_last marks the final beat of a request.
// Each step of an insert, search or merge walk takes a read state and then a
// check state, set by the single read port of each record RAM, whose read is
// registered.
// The output register frees the datapath as soon as a beat is loaded; while
// rsp_stall is high the beat holds and the walk pauses before the next one.
// Reset empties both tables (fill counts to zero) and drops any beat in
// flight; the record RAMs are not cleared, as only filled entries are used.
module sorted_record_table_with_merge_core #(
   parameter int TABLE_DEPTH = srtm_pkg::TABLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic               req_table_sel,
   input  logic [30:0]        req_record_id,
   input  logic signed [15:0] req_key_value,
   input  logic [63:0]        req_name_text,
   input  logic signed [15:0] req_threshold,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [30:0]        rsp_out_id,
   output logic signed [15:0] rsp_out_key,
   output logic [63:0]        rsp_out_name,
   output logic               rsp_last
);

   srtm_pkg::cmd_type cmd;
   srtm_pkg::sts_type sts;

   // sequence the walks
   srtm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // hold the records and drive the response beats
   srtm_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_operation (req_operation),
      .req_table_sel (req_table_sel),
      .req_record_id (req_record_id),
      .req_key_value (req_key_value),
      .req_name_text (req_name_text),
      .req_threshold (req_threshold),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_out_id    (rsp_out_id),
      .rsp_out_key   (rsp_out_key),
      .rsp_out_name  (rsp_out_name),
      .rsp_last      (rsp_last)
   );

endmodule

// ===== rtl/srtm_checker.sv =====
// Port-level checks on the sorted record table, bound to the top level.
module srtm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [30:0] rsp_out_id,
   input logic [15:0] rsp_out_key,
   input logic [63:0] rsp_out_name,
   input logic        rsp_last
);

   // a stalled beat stays
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped under stall");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_status) && $stable(rsp_out_id))
      else $error("stalled response beat changed");

   // every status other than a record closes its request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != srtm_pkg::ST_RECORD) |-> rsp_last)
      else $error("non-record status without last");

   // miss and empty beats carry no record
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == srtm_pkg::ST_MISS) ||
                    (rsp_status == srtm_pkg::ST_EMPTY))
      |-> (rsp_out_id == '0) && (rsp_out_key == '0) && (rsp_out_name == '0))
      else $error("miss or empty beat carries record data");

endmodule

bind sorted_record_table_with_merge_core srtm_checker u_srtm_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_status   (rsp_status),
   .rsp_out_id   (rsp_out_id),
   .rsp_out_key  (rsp_out_key),
   .rsp_out_name (rsp_out_name),
   .rsp_last     (rsp_last)
);
